// ===== hw/rtl/tegr_pkg.sv =====
// ----------------------------------------------------------------------------
// tegr_pkg
// shared constants, item kinds and neighbor offsets for the erosion grid
// ----------------------------------------------------------------------------
`default_nettype none

package tegr_pkg;

  localparam int INT_BITS      = 12;
  localparam int GRID_SIDE_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TENTH_NUM     = 6554;
  localparam int TENTH_SHIFT   = 16;
  localparam int TENTH_W       = 13;
  localparam int ITER_W        = 8;
  localparam logic [ITER_W-1:0] ITER_RESET = 8'd3;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;

  // step 0 is the center, steps 1..8 the eight neighbors
  function automatic int nb_off(input int side, input int step);
    int off;
    off = 0;
    case (step)
      1:       off = -side - 1;
      2:       off = -side;
      3:       off = -side + 1;
      4:       off = -1;
      5:       off = 1;
      6:       off = side - 1;
      7:       off = side;
      8:       off = side + 1;
      default: off = 0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tegr_ram.sv =====
// ----------------------------------------------------------------------------
// tegr_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
`default_nettype none

module tegr_ram #(
  parameter int W     = 28,
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tegr_tenth.sv =====
// ----------------------------------------------------------------------------
// tegr_tenth
// shared scaling unit: registered truncated tenth of a fixed point value
// ----------------------------------------------------------------------------
`default_nettype none

module tegr_tenth
  import tegr_pkg::*;
#(
  parameter int W = 31
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] v,
  output logic      [W-1:0] q
);

  logic [W+TENTH_W-1:0] prod;

  assign prod = (W+TENTH_W)'(v) * (W+TENTH_W)'(TENTH_NUM);

  always_ff @(posedge clk) begin
    q <= W'(prod >> TENTH_SHIFT);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/thermal_erosion_grid_core.sv =====
// ----------------------------------------------------------------------------
// thermal_erosion_grid_core
// heightmap store with thermal erosion passes
// ----------------------------------------------------------------------------
// input items arrive on s_tvalid/s_tready; s_tuser is the kind (write, read,
// run), s_tdata carries row, col and height. results leave on
// m_tvalid/m_tready with the height in m_tdata and the run flag in m_tuser.
// a write gives no result. a read waits in S_RD for the result register,
// then presents its result there. a run gives one result once all passes
// are done. one pass runs a copy sweep over the grid, gathers the neighbors
// of each interior cell in turn, applies the shed of each cell that sheds
// material through the shared scaling unit, and ends with a commit sweep;
// the one read port of each grid memory makes these steps run in turn.
// s_tready is high only while no read or run is in progress.
// a stalled receiver holds the result register; writes are still taken,
// while a read or run waits in its final state for the register to free.
// rst clears control state and sets the pass count to three; grid contents
// are not cleared and must be written before they are read or eroded.
// cfg_we writes the pass count; use it only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_erosion_grid_core
  import tegr_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [ITER_W-1:0] cfg_wdata,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [23:0]       s_tdata,   // row[5:0], col[11:6], height_in[23:12]
  input  wire logic [1:0]        s_tuser,   // kind[1:0]
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [15:0]       m_tdata,   // height_out[11:0], zero[15:12]
  output logic                   m_tuser    // run_done[0]
);

  localparam int HW    = INT_BITS + FRAC_BITS;
  localparam int NW    = HW + 3;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = AW + 1;
  localparam int RW    = $clog2(GRID_SIDE);
  localparam logic [NW-1:0] ONE_FIX = NW'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_COPY, S_GATHER, S_DECIDE, S_APPLY, S_COMMIT, S_DONE
  } state_t;

  state_t            state;
  logic              out_valid;
  logic [11:0]       out_height;
  logic              out_done;
  logic [ITER_W-1:0] iter_cnt;
  logic [ITER_W-1:0] pass_cnt;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     ci;
  logic [RW-1:0]     r_i;
  logic [RW-1:0]     c_i;
  logic [3:0]        step;
  logic [HW-1:0]     h;
  logic [NW-1:0]     total;
  logic [HW-1:0]     drop [8];
  logic [7:0]        lower;
  logic [AW-1:0]     io_addr_q;
  logic              io_inside_q;
  logic              ap_v;
  logic              ap_sub;
  logic [AW-1:0]     ap_addr;

  logic [5:0]    in_row;
  logic [5:0]    in_col;
  logic [11:0]   in_height;
  logic          in_acc;
  logic          in_inside;
  logic [AW-1:0] io_addr;
  logic [AW-1:0] nb_addr;
  logic          slot_free;
  logic          res_load;
  logic [AW-1:0] cnt_addr;
  logic [AW-1:0] cnt_prev;

  logic          h_we;
  logic [AW-1:0] h_waddr;
  logic [HW-1:0] h_wdata;
  logic [AW-1:0] h_raddr;
  logic [HW-1:0] h_rdata;
  logic          n_we;
  logic [AW-1:0] n_waddr;
  logic [NW-1:0] n_wdata;
  logic [AW-1:0] n_raddr;
  logic [NW-1:0] n_rdata;
  logic [HW-1:0] n_sat;
  logic [NW-1:0] tn_in;
  logic [NW-1:0] tn_q;
  logic [2:0]    drop_idx;
  logic [3:0]    step_m1;
  logic [3:0]    step_m2;
  logic [2:0]    gat_idx;

  assign in_row    = s_tdata[5:0];
  assign in_col    = s_tdata[11:6];
  assign in_height = s_tdata[23:12];
  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign in_inside = (32'(in_row) < GRID_SIDE) && (32'(in_col) < GRID_SIDE);
  assign io_addr   = AW'(32'(in_row) * 32'(GRID_SIDE) + 32'(in_col));
  assign nb_addr   = ci + AW'(nb_off(GRID_SIDE, 32'(step)));
  assign slot_free = !out_valid || m_tready;
  assign res_load  = slot_free && (state == S_RD || state == S_DONE);
  assign cnt_addr  = cnt[AW-1:0];
  assign cnt_prev  = AW'(cnt - CW'(1));
  assign step_m1   = step - 4'd1;
  assign drop_idx  = step_m1[2:0];
  assign step_m2   = step - 4'd2;
  assign gat_idx   = step_m2[2:0];

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_height};
  assign m_tuser  = out_done;

  always_comb begin
    if (n_rdata[NW-1]) begin
      n_sat = '0;
    end else if (|n_rdata[NW-2:HW]) begin
      n_sat = '1;
    end else begin
      n_sat = n_rdata[HW-1:0];
    end
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = io_addr;
    h_wdata = {in_height, FRAC_BITS'(0)};
    if (state == S_COMMIT) begin
      h_we    = (cnt != '0);
      h_waddr = cnt_prev;
      h_wdata = n_sat;
    end else if (in_acc && s_tuser == KIND_WRITE && in_inside) begin
      h_we = 1'b1;
    end
    case (state)
      S_IDLE:   h_raddr = io_addr;
      S_RD:     h_raddr = io_addr_q;
      S_GATHER: h_raddr = nb_addr;
      default:  h_raddr = cnt_addr;
    endcase
  end

  always_comb begin
    n_we    = 1'b0;
    n_waddr = cnt_prev;
    n_wdata = NW'(h_rdata);
    if (state == S_COPY) begin
      n_we = (cnt != '0);
    end else if (state == S_APPLY) begin
      n_we    = ap_v;
      n_waddr = ap_addr;
      n_wdata = ap_sub ? (n_rdata - tn_q) : (n_rdata + tn_q);
    end
    n_raddr = (state == S_APPLY) ? nb_addr : cnt_addr;
  end

  assign tn_in = (step == 4'd0) ? total : NW'(drop[drop_idx]);

  tegr_ram #(.W(HW), .DEPTH(CELLS), .AW(AW)) u_hgrid (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  tegr_ram #(.W(NW), .DEPTH(CELLS), .AW(AW)) u_ngrid (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  tegr_tenth #(.W(NW)) u_tenth (
    .clk(clk), .v(tn_in), .q(tn_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      iter_cnt  <= ITER_RESET;
      pass_cnt  <= '0;
      ap_v      <= 1'b0;
    end else begin
      if (cfg_we) begin
        iter_cnt <= cfg_wdata;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      ap_v <= (state == S_APPLY) && (step != 4'd9) && ((step == 4'd0) || lower[drop_idx]);
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            io_addr_q   <= io_addr;
            io_inside_q <= in_inside;
            if (s_tuser == KIND_READ) begin
              state <= S_RD;
            end else if (s_tuser == KIND_RUN) begin
              pass_cnt <= '0;
              cnt      <= '0;
              state    <= (iter_cnt == '0) ? S_DONE : S_COPY;
            end
          end
        end
        S_RD: begin
          if (slot_free) begin
            out_height <= io_inside_q ? h_rdata[HW-1:FRAC_BITS] : 12'd0;
            out_done   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_COPY: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(CELLS)) begin
            ci    <= AW'(GRID_SIDE + 1);
            r_i   <= RW'(1);
            c_i   <= RW'(1);
            step  <= '0;
            state <= S_GATHER;
          end
        end
        S_GATHER: begin
          if (step == 4'd9) begin
            step  <= '0;
            state <= S_DECIDE;
          end else begin
            step <= step + 4'd1;
          end
          if (step == 4'd0) begin
            total <= '0;
          end else if (step == 4'd1) begin
            h <= h_rdata;
          end else begin
            if (h_rdata < h) begin
              drop[gat_idx]  <= h - h_rdata;
              lower[gat_idx] <= 1'b1;
              total          <= total + NW'(h - h_rdata);
            end else begin
              lower[gat_idx] <= 1'b0;
            end
          end
        end
        S_DECIDE, S_APPLY: begin
          if (state == S_APPLY && step != 4'd9) begin
            step    <= step + 4'd1;
            ap_sub  <= (step == 4'd0);
            ap_addr <= nb_addr;
          end else if (state == S_DECIDE && total > ONE_FIX) begin
            state <= S_APPLY;
          end else begin
            step <= '0;
            if (c_i == RW'(GRID_SIDE - 2)) begin
              if (r_i == RW'(GRID_SIDE - 2)) begin
                cnt   <= '0;
                state <= S_COMMIT;
              end else begin
                r_i   <= r_i + RW'(1);
                c_i   <= RW'(1);
                ci    <= ci + AW'(3);
                state <= S_GATHER;
              end
            end else begin
              c_i   <= c_i + RW'(1);
              ci    <= ci + AW'(1);
              state <= S_GATHER;
            end
          end
        end
        S_COMMIT: begin
          if (cnt == CW'(CELLS)) begin
            pass_cnt <= pass_cnt + ITER_W'(1);
            cnt      <= '0;
            state    <= (pass_cnt + ITER_W'(1) == iter_cnt) ? S_DONE : S_COPY;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_height <= 12'd0;
            out_done   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 16'd0)
    else $error("run acknowledge carries a height");

  a_apply_total: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> total > ONE_FIX)
    else $error("cell sheds without enough drop");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY |-> pass_cnt < iter_cnt)
    else $error("pass count overrun");

  a_new_result_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid)
    else $error("pending result dropped");
`endif

endmodule

`default_nettype wire
